[design/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg: shared definitions for the periodic task dispatcher
// Widths, reset values, item kinds, register indexes and the status word
// passed from the remainder unit to the dispatcher sequencer.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int TICK_W     = 16;
    localparam int CNT_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int RUN_W      = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  TASK_COUNT_RESET = CNT_W'(1);
    localparam logic [TICK_W-1:0] WRAP_RESET       = TICK_W'(1000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT = CFG_IDX_W'(2);

    // Scheduling modes.
    localparam logic MODE_PERIODIC    = 1'b0;
    localparam logic MODE_ROUND_ROBIN = 1'b1;

    // Item kinds; the fourth code carries no meaning.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_YIELD = 2'd1,
        KIND_LOAD  = 2'd2
    } t_kind;

    // Status of the remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_stat;

endpackage

[design/ptd_rem_unit.sv]
// ----------------------------------------------------------------------------
// ptd_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module ptd_rem_unit
    import ptd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [TICK_W-1:0] i_divisor,
    output t_rem_stat         o_stat
);

    localparam int STEP_W = $clog2(TICK_W);

    logic                r_active;
    logic [STEP_W-1:0]   r_step;
    logic [TICK_W-1:0]   r_rem;
    logic [TICK_W-1:0]   r_dvd;
    logic [TICK_W-1:0]   r_dvs;
    logic                r_done;
    logic                r_zero;

    logic [TICK_W:0]     rem_sh;
    logic [TICK_W:0]     diff;
    logic [TICK_W-1:0]   n_rem;

    // The partial remainder stays below the divisor, so one shift and one
    // conditional subtract give the next one.
    always_comb begin
        rem_sh = {r_rem, r_dvd[TICK_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_rem  = (rem_sh >= {1'b0, r_dvs}) ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_zero   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= '0;
                r_rem    <= '0;
                r_dvd    <= i_dividend;
                r_dvs    <= i_divisor;
            end else if (r_active) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(TICK_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                    r_zero   <= (n_rem == '0);
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = r_zero;

endmodule

[design/periodic_task_dispatcher.sv]
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: periodic release and dispatch of tasks
// Keeps a period per task, pending marks, a tick counter, the running task;
// periodic ticks release tasks whose period divides the counter and dispatch.
// ----------------------------------------------------------------------------
// Usage. A word is offered on i_kind, i_task_slot and i_period_ticks with
// i_start; it is taken at a clock edge where i_start is high and o_busy is
// low. Every word yields exactly one result word, shown for one cycle with
// o_result_valid; the receiver cannot hold it off and need not.
// Configuration words (task count, scheduling mode, wrap limit) are written
// through i_cfg_valid/o_cfg_ready, index and data, while the block is idle.
// Flow. Period loads, round-robin ticks and the unused kind give their
// result the cycle after acceptance and the block stays ready. A yield
// searches the pending marks one task per cycle, then gives the result.
// A periodic tick walks the N tasks in use through one shared bit-serial
// remainder unit: a table read and a check for each task, and for a task
// with a nonzero period also the remainder steps, one per counter bit,
// and the done pulse; then the search. o_busy stays high until the
// result is shown.
// Reset (synchronous, active low) clears the counter, running task, pending
// marks and period valid bits, and loads the register reset values.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [SLOT_W-1:0]     i_task_slot,
    input  logic [TICK_W-1:0]     i_period_ticks,
    output logic                  o_result_valid,
    output logic [RUN_W-1:0]      o_running_task,
    output logic                  o_was_pending,
    output logic [TICK_W-1:0]     o_tick_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // TW indexes a task; SW also holds the task count itself.
    localparam int TW = $clog2(MAX_TASKS);
    localparam int SW = TW + 1;
    localparam int CW = (SW > CNT_W) ? SW : CNT_W;
    localparam int XW = TW + SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DIV,
        S_SEARCH
    } t_state;

    // Configuration registers.
    logic [CNT_W-1:0]     r_task_count;
    logic                 r_mode;
    logic [TICK_W-1:0]    r_wrap;

    // Sequencer and block state.
    t_state               r_state;
    t_kind                r_kind;
    logic [TW-1:0]        r_cur;
    logic [TW-1:0]        r_srch;
    logic [TW-1:0]        r_idx;
    logic [TICK_W-1:0]    r_tick;
    logic [MAX_TASKS-1:0] r_pend;
    logic [MAX_TASKS-1:0] r_pvalid;

    // Period table and its registered read port.
    logic [TICK_W-1:0]    r_period_mem [MAX_TASKS];
    logic [TICK_W-1:0]    r_rd_data;
    logic                 r_rd_ok;

    // Result registers.
    logic                 r_o_valid;
    logic [TW-1:0]        r_o_task;
    logic                 r_o_pend;
    logic [TICK_W-1:0]    r_o_tick;

    logic                 accept;
    logic [CW-1:0]        tc_ext;
    logic [CW-1:0]        live_c;
    logic [SW-1:0]        live;
    logic [SW-1:0]        idle_s;
    logic [TW-1:0]        idle_task;
    logic [SW-1:0]        idx_inc;
    logic                 last_task;
    logic [XW-1:0]        slot_ext;
    logic                 slot_ok;
    logic                 mem_wr;
    logic [TICK_W-1:0]    period;
    logic                 div_start;
    t_rem_stat            rem_stat;
    logic [TW-1:0]        succ_cur;
    logic [TW-1:0]        succ_srch;
    logic                 hit;
    logic [TW-1:0]        n_sel;
    logic [TICK_W-1:0]    n_tick_end;
    logic [TW+RUN_W-1:0]  run_ext;

    // Next task in circular order; a successor at or beyond the count wraps to 0.
    function automatic logic [TW-1:0] succ(input logic [TW-1:0] t,
                                           input logic [SW-1:0] n);
        logic [SW-1:0] t1;
        t1 = {1'b0, t} + SW'(1);
        return (t1 < n) ? t1[TW-1:0] : '0;
    endfunction

    assign accept = i_start && (r_state == S_IDLE);

    // Number of tasks in use: a count of zero acts as one, and a count
    // above the table size acts as the table size.
    assign tc_ext = CW'(r_task_count);
    always_comb begin
        priority if (tc_ext == '0) begin
            live_c = CW'(1);
        end else if (tc_ext > CW'(MAX_TASKS)) begin
            live_c = CW'(MAX_TASKS);
        end else begin
            live_c = tc_ext;
        end
    end
    assign live      = live_c[SW-1:0];
    assign idle_s    = live - SW'(1);
    assign idle_task = idle_s[TW-1:0];

    // r_idx walks the tasks during the release sweep and counts the
    // candidates during the search.
    assign idx_inc   = {1'b0, r_idx} + SW'(1);
    assign last_task = (idx_inc == live);

    assign slot_ext = {{TW{1'b0}}, i_task_slot};
    assign slot_ok  = (slot_ext < XW'(MAX_TASKS));
    assign mem_wr   = accept && (i_kind == KIND_LOAD) && slot_ok;

    // An entry never written reads as period zero.
    assign period    = r_rd_ok ? r_rd_data : '0;
    assign div_start = (r_state == S_CHECK) && (period != '0);

    assign succ_cur  = succ(r_cur, live);
    assign succ_srch = succ(r_srch, live);
    assign hit       = r_pend[succ_srch];
    assign n_sel     = hit ? succ_srch : idle_task;

    // The counter restarts only after a periodic tick's release check.
    assign n_tick_end = ((r_kind == KIND_TICK) && (r_tick >= r_wrap)) ? '0 : r_tick;

    ptd_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tick),
        .i_divisor  (period),
        .o_stat     (rem_stat)
    );

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_period_mem[slot_ext[TW-1:0]] <= i_period_ticks;
        end
        r_rd_data <= r_period_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RESET;
            r_mode       <= MODE_PERIODIC;
            r_wrap       <= WRAP_RESET;
            r_state      <= S_IDLE;
            r_kind       <= KIND_TICK;
            r_cur        <= '0;
            r_srch       <= '0;
            r_idx        <= '0;
            r_tick       <= '0;
            r_pend       <= '0;
            r_pvalid     <= '0;
            r_rd_ok      <= 1'b0;
            r_o_valid    <= 1'b0;
            r_o_task     <= '0;
            r_o_pend     <= 1'b0;
            r_o_tick     <= '0;
        end else begin
            r_o_valid <= 1'b0;
            r_rd_ok   <= r_pvalid[r_idx];

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TASK_COUNT: r_task_count <= i_cfg_data[CNT_W-1:0];
                    CFG_SCHED_MODE: r_mode       <= i_cfg_data[0];
                    CFG_WRAP_LIMIT: r_wrap       <= i_cfg_data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (mem_wr) begin
                r_pvalid[slot_ext[TW-1:0]] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= t_kind'(i_kind);
                        unique case (i_kind)
                            KIND_TICK: begin
                                if (r_mode == MODE_PERIODIC) begin
                                    r_tick  <= r_tick + TICK_W'(1);
                                    r_idx   <= '0;
                                    r_state <= S_READ;
                                end else begin
                                    r_cur     <= succ_cur;
                                    r_o_valid <= 1'b1;
                                    r_o_task  <= succ_cur;
                                    r_o_pend  <= 1'b0;
                                    r_o_tick  <= r_tick;
                                end
                            end
                            KIND_YIELD: begin
                                r_srch  <= r_cur;
                                r_idx   <= '0;
                                r_state <= S_SEARCH;
                            end
                            default: begin
                                r_o_valid <= 1'b1;
                                r_o_task  <= r_cur;
                                r_o_pend  <= 1'b0;
                                r_o_tick  <= r_tick;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (period != '0) begin
                        r_state <= S_DIV;
                    end else if (last_task) begin
                        r_idx   <= '0;
                        r_srch  <= r_cur;
                        r_state <= S_SEARCH;
                    end else begin
                        r_idx   <= idx_inc[TW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        if (rem_stat.rem_zero) begin
                            r_pend[r_idx] <= 1'b1;
                        end
                        if (last_task) begin
                            r_idx   <= '0;
                            r_srch  <= r_cur;
                            r_state <= S_SEARCH;
                        end else begin
                            r_idx   <= idx_inc[TW-1:0];
                            r_state <= S_READ;
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit || last_task) begin
                        r_pend[n_sel] <= 1'b0;
                        r_cur         <= n_sel;
                        r_tick        <= n_tick_end;
                        r_o_valid     <= 1'b1;
                        r_o_task      <= n_sel;
                        r_o_pend      <= hit;
                        r_o_tick      <= n_tick_end;
                        r_state       <= S_IDLE;
                    end else begin
                        r_srch <= succ_srch;
                        r_idx  <= idx_inc[TW-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign run_ext        = {{RUN_W{1'b0}}, r_o_task};
    assign o_running_task = run_ext[RUN_W-1:0];
    assign o_was_pending  = r_o_pend;
    assign o_tick_value   = r_o_tick;
    assign o_result_valid = r_o_valid;
    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);

endmodule

[design/ptd_checker.sv]
// ----------------------------------------------------------------------------
// ptd_checker: port-level checks for the periodic task dispatcher
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module ptd_checker
    import ptd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  o_busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic                  o_result_valid,
    input  logic                  o_was_pending,
    input  logic [TICK_W-1:0]     o_tick_value
);

    // The block only becomes busy because a word was taken.
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without an accepted word");

    // A result is only shown once the work on its word is over.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_busy)
        else $error("result shown while still busy");

    // A period load answers at once, finds nothing and leaves the counter.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_kind == KIND_LOAD))
        |=> (o_result_valid && !o_was_pending && $stable(o_tick_value)))
        else $error("period load gave a wrong result");

    // A tick or a yield is either answered at once or keeps the block busy.
    a_work_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && ((i_kind == KIND_TICK) || (i_kind == KIND_YIELD)))
        |=> (o_busy || o_result_valid))
        else $error("tick or yield was dropped");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (.*);
